FILE: hw/rtl/qrs_pkg.sv
// Shared types and default constants for the quadratic root solver.
// No dependencies.
package qrs_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COEF_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_ONE   = 2'd1,
    ST_NONE  = 2'd2,
    ST_AZERO = 2'd3
  } status_t;

endpackage

FILE: hw/rtl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on qrs_pkg.
module qrs_sqrt #(
  parameter int DW = 67,
  parameter int RW = 34,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic [SW-1:0] out_side
);
  import qrs_pkg::*;

  localparam int TW = (2 * RW > DW) ? 2 * RW : DW;

  logic          vld  [0:RW];
  logic [TW-1:0] rem  [0:RW];
  logic [RW-1:0] root [0:RW];
  logic [SW-1:0] side [0:RW];

  assign vld[0]  = in_valid;
  assign rem[0]  = TW'(in_rad);
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int K = RW - 1 - s;
    logic [TW-1:0] trial;
    logic          ge;

    assign trial = (TW'(root[s]) << (K + 1)) + (TW'(1) << (2 * K));
    assign ge    = rem[s] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1]  <= ge ? rem[s] - trial : rem[s];
      root[s+1] <= ge ? (root[s] | (RW'(1) << K)) : root[s];
      side[s+1] <= side[s];
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];

endmodule

FILE: hw/rtl/qrs_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on qrs_pkg.
module qrs_div #(
  parameter int NW  = 50,
  parameter int DVW = 33,
  parameter int SW  = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_num,
  input  logic [DVW-1:0] in_den,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [NW-1:0]  out_quo,
  output logic [SW-1:0]  out_side
);
  import qrs_pkg::*;

  localparam int RWD = DVW + 1;

  logic           vld  [0:NW];
  logic [DVW-1:0] rem  [0:NW];
  logic [NW-1:0]  num  [0:NW];
  logic [NW-1:0]  quo  [0:NW];
  logic [DVW-1:0] den  [0:NW];
  logic [SW-1:0]  side [0:NW];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign num[0]  = in_num;
  assign quo[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [RWD-1:0] trial;
    logic [RWD-1:0] diff;
    logic           ge;

    assign trial = {rem[s], num[s][NW-1-s]};
    assign ge    = trial >= {1'b0, den[s]};
    assign diff  = trial - {1'b0, den[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1]  <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
      num[s+1]  <= num[s];
      quo[s+1]  <= {quo[s][NW-2:0], ge};
      den[s+1]  <= den[s];
      side[s+1] <= side[s];
    end
  end

  assign out_valid = vld[NW];
  assign out_quo   = quo[NW];
  assign out_side  = side[NW];

endmodule

FILE: hw/rtl/quadratic_root_solver_core.sv
// Quadratic root solver top level: discriminant, square root and divide pipeline.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
//
// Fully pipelined: busy is always low, so a coefficient set may be started
// every cycle and one result per set comes out on done, in order. A set
// passes through the decode, product and discriminant registers, one
// square-root stage per root bit, the numerator register, one divider
// stage per quotient bit and the output register. The receiver cannot stall;
// results are shown for one cycle only.
module quadratic_root_solver_core #(
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COEF_WIDTH-1:0] coef_a,
  input  logic signed [COEF_WIDTH-1:0] coef_b,
  input  logic signed [COEF_WIDTH-1:0] coef_c,
  output logic                         done,
  output qrs_pkg::status_t             status,
  output logic signed [COEF_WIDTH-1:0] root_low,
  output logic signed [COEF_WIDTH-1:0] root_high,
  output logic                         saturated
);
  import qrs_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int DW   = 2 * W + 3;
  localparam int RW   = W + 2;
  localparam int NUMW = W + 3;
  localparam int MW   = W + 2;
  localparam int NW   = MW + FRAC_BITS;
  localparam int DVW  = W + 1;
  localparam int SW1  = 2 * W + 4;
  localparam int SW2  = 4;

  assign busy = 1'b0;

  // decode
  logic         a_vld;
  logic [W-1:0] a_ma, a_mb, a_mc;
  logic         a_na, a_nb, a_nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start;
    end
    a_na <= coef_a[W-1];
    a_nb <= coef_b[W-1];
    a_nc <= coef_c[W-1];
    a_ma <= coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
    a_mb <= coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
    a_mc <= coef_c[W-1] ? W'(-coef_c) : W'(coef_c);
  end

  // products
  logic           b_vld;
  logic [2*W-1:0] b_b2, b_ac;
  logic [W-1:0]   b_ma, b_mb;
  logic           b_na, b_nb, b_nc, b_az;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_b2 <= a_mb * a_mb;
    b_ac <= a_ma * a_mc;
    b_ma <= a_ma;
    b_mb <= a_mb;
    b_na <= a_na;
    b_nb <= a_nb;
    b_nc <= a_nc;
    b_az <= (a_ma == '0);
  end

  // discriminant
  logic [DW-1:0] b2x, ac4, d_sum, d_dif, d_val;
  logic          addmode, negd;
  status_t       d_st;

  assign b2x     = DW'(b_b2);
  assign ac4     = {1'b0, b_ac, 2'b00};
  assign addmode = (b_na != b_nc) && (b_ac != '0);
  assign d_sum   = b2x + ac4;
  assign d_dif   = b2x - ac4;
  assign negd    = !addmode && (b2x < ac4);
  assign d_val   = addmode ? d_sum : d_dif;

  always_comb begin
    if (b_az) begin
      d_st = ST_AZERO;
    end else if (negd) begin
      d_st = ST_NONE;
    end else if (d_val == '0) begin
      d_st = ST_ONE;
    end else begin
      d_st = ST_TWO;
    end
  end

  logic           c_vld;
  logic [DW-1:0]  c_d;
  logic [SW1-1:0] c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_d    <= d_val;
    c_side <= {d_st, b_na, b_nb, b_ma, b_mb};
  end

  logic           s_vld;
  logic [RW-1:0]  s_root;
  logic [SW1-1:0] s_side;

  qrs_sqrt #(.DW(DW), .RW(RW), .SW(SW1)) u_sqrt (
    .clk(clk), .rst(rst),
    .in_valid(c_vld), .in_rad(c_d), .in_side(c_side),
    .out_valid(s_vld), .out_root(s_root), .out_side(s_side)
  );

  // numerators -b -/+ s
  logic [1:0]            s_st;
  logic                  s_na, s_nb;
  logic [W-1:0]          s_ma, s_mb;
  logic signed [NUMW-1:0] bvs, sx, nm, np;

  assign {s_st, s_na, s_nb, s_ma, s_mb} = s_side;
  assign sx  = NUMW'(s_root);
  assign bvs = s_nb ? -$signed(NUMW'(s_mb)) : $signed(NUMW'(s_mb));
  assign nm  = -bvs - sx;
  assign np  = -bvs + sx;

  logic          n_vld;
  logic [MW-1:0] n_mm, n_mp;
  logic          n_negm, n_negp, n_na;
  logic [1:0]    n_st;
  logic [W-1:0]  n_ma;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else begin
      n_vld <= s_vld;
    end
    n_negm <= nm[NUMW-1];
    n_negp <= np[NUMW-1];
    n_mm   <= nm[NUMW-1] ? MW'(-nm) : MW'(nm);
    n_mp   <= np[NUMW-1] ? MW'(-np) : MW'(np);
    n_na   <= s_na;
    n_st   <= s_st;
    n_ma   <= s_ma;
  end

  logic           q_vld, q_vld2;
  logic [NW-1:0]  q_m, q_p;
  logic [SW2-1:0] q_side;
  logic           q_negp_side;

  qrs_div #(.NW(NW), .DVW(DVW), .SW(SW2)) u_div_m (
    .clk(clk), .rst(rst),
    .in_valid(n_vld), .in_num({n_mm, {FRAC_BITS{1'b0}}}), .in_den({n_ma, 1'b0}),
    .in_side({n_st, n_na, n_negm}),
    .out_valid(q_vld), .out_quo(q_m), .out_side(q_side)
  );

  qrs_div #(.NW(NW), .DVW(DVW), .SW(1)) u_div_p (
    .clk(clk), .rst(rst),
    .in_valid(n_vld), .in_num({n_mp, {FRAC_BITS{1'b0}}}), .in_den({n_ma, 1'b0}),
    .in_side(n_negp),
    .out_valid(q_vld2), .out_quo(q_p), .out_side(q_negp_side)
  );

  // sign, clamp and order
  function automatic logic [W:0] fin_root(input logic [NW-1:0] q, input logic nneg,
                                           input logic aneg);
    logic          neg;
    logic [NW-1:0] lim;
    logic [W-1:0]  mag;
    logic          sat;
    neg = (nneg != aneg) && (q != '0);
    lim = neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
    sat = q > lim;
    mag = sat ? lim[W-1:0] : q[W-1:0];
    return {sat, neg ? W'(-mag) : mag};
  endfunction

  logic [1:0] f_st;
  logic       f_na, f_negm;
  logic [W:0] r_m, r_p;

  assign {f_st, f_na, f_negm} = q_side;
  assign r_m = fin_root(q_m, f_negm, f_na);
  assign r_p = fin_root(q_p, q_negp_side, f_na);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_vld && q_vld2;
    end
    status <= status_t'(f_st);
    if (f_st == ST_NONE || f_st == ST_AZERO) begin
      root_low  <= '0;
      root_high <= '0;
      saturated <= 1'b0;
    end else begin
      root_low  <= f_na ? r_p[W-1:0] : r_m[W-1:0];
      root_high <= f_na ? r_m[W-1:0] : r_p[W-1:0];
      saturated <= r_m[W] | r_p[W];
    end
  end

endmodule

FILE: dv/quadratic_root_solver_checker.sv
`timescale 1ns / 100ps
// Checker for the quadratic root solver: predicts each result from the accepted
// coefficient set and compares it with the block's output. Depends on qrs_pkg.
module quadratic_root_solver_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] coef_a,
  input  logic signed [31:0] coef_b,
  input  logic signed [31:0] coef_c,
  input  logic               done,
  input  qrs_pkg::status_t   status,
  input  logic signed [31:0] root_low,
  input  logic signed [31:0] root_high,
  input  logic               saturated,
  output int                 fail_count,
  output int                 pending
);
  import qrs_pkg::*;

  typedef struct packed {
    status_t            st;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               sat;
  } roots_t;

  roots_t expected_roots[$];
  int mismatches;

  assign fail_count = mismatches;
  assign pending    = expected_roots.size();

  function automatic logic [65:0] isqrt_floor(logic [65:0] n);
    logic [65:0] res;
    logic [65:0] bitv;
    res  = '0;
    bitv = 66'd1 << 64;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // num * 2^16 / (2a), toward zero, clamped to 32 bits
  function automatic logic signed [31:0] scaled_root(input logic signed [67:0] num,
                                                     input logic signed [67:0] a,
                                                     inout logic sat);
    logic signed [67:0] q;
    q = (num <<< 16) / (a * 2);
    if (q > 68'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -68'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic roots_t solve_quadratic(logic signed [31:0] a, logic signed [31:0] b,
                                             logic signed [31:0] c);
    roots_t r;
    logic signed [67:0] disc;
    logic signed [67:0] s;
    logic sat;
    logic signed [31:0] rm;
    logic signed [31:0] rp;
    r = '{st: ST_TWO, lo: '0, hi: '0, sat: 1'b0};
    sat = 1'b0;
    if (a == 0) begin
      r.st = ST_AZERO;
      return r;
    end
    disc = 68'(b) * 68'(b) - 68'sd4 * 68'(a) * 68'(c);
    if (disc < 0) begin
      r.st = ST_NONE;
      return r;
    end
    s  = $signed({2'b00, isqrt_floor(disc[65:0])});
    rm = scaled_root(-68'(b) - s, 68'(a), sat);
    rp = scaled_root(-68'(b) + s, 68'(a), sat);
    r.st  = (disc == 0) ? ST_ONE : ST_TWO;
    r.lo  = (a > 0) ? rm : rp;
    r.hi  = (a > 0) ? rp : rm;
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    roots_t e;
    if (rst) begin
      mismatches <= 0;
    end else begin
      if (done) begin
        if (expected_roots.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result transfer st=%0d", status);
        end else begin
          e = expected_roots.pop_front();
          if (status !== e.st || root_low !== e.lo || root_high !== e.hi ||
              saturated !== e.sat) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp st=%0d lo=%h hi=%h sat=%b, got st=%0d lo=%h hi=%h sat=%b",
                       e.st, e.lo, e.hi, e.sat, status, root_low, root_high, saturated);
          end
        end
      end
      if (start && !busy) expected_roots.push_back(solve_quadratic(coef_a, coef_b, coef_c));
    end
  end

endmodule

FILE: dv/tb_quadratic_root_solver_core.sv
`timescale 1ns / 100ps
// Testbench top for quadratic_root_solver_core: directed and random coefficient
// sets with varied start idling. Depends on qrs_pkg and the checker module.
module tb_quadratic_root_solver_core;
  import qrs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] coef_a = '0;
  logic signed [31:0] coef_b = '0;
  logic signed [31:0] coef_c = '0;
  logic done;
  status_t status;
  logic signed [31:0] root_low;
  logic signed [31:0] root_high;
  logic saturated;
  int fail_count;
  int pending;
  int cycles = 0;
  int idle_pct = 0;

  always #6 clk = ~clk;

  quadratic_root_solver_core dut (.*);
  quadratic_root_solver_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_coefs(logic signed [31:0] a, logic signed [31:0] b,
                            logic signed [31:0] c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(2047)) - 1024;
      2: return ($signed($urandom_range(1023)) - 512) <<< 16;
      3: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      default: return ($signed($urandom_range(63)) - 32) <<< $urandom_range(20, 8);
    endcase
  endfunction

  initial begin
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic signed [31:0] a;
    int wait_cycles;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: a zero, negative/zero/positive discriminant, extremes, saturation
    send_coefs(0, 32'sh7fffffff, 32'sh80000000);
    send_coefs(32'sh10000, 0, 32'sh10000);
    send_coefs(32'sh10000, 32'sh20000, 32'sh10000);
    send_coefs(32'sh10000, 0, -32'sh40000);
    send_coefs(-32'sh10000, 32'sh30000, -32'sh20000);
    send_coefs(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_coefs(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_coefs(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_coefs(1, 32'sh7fffffff, 0);
    send_coefs(-1, 32'sh80000000, 32'sh7fffffff);
    send_coefs(32'sh7fffffff, 0, 32'sh80000000);
    send_coefs(1, 0, -1);
    send_coefs(32'shffffffff, 32'shffffffff, 32'shffffffff);
    send_coefs(3, 1, 0);
    send_coefs(32'sh10000, 32'sh80000000, 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 74 : (ph == 3) ? 12 : 0;
      for (int i = 0; i < 135; i++) begin
        if ($urandom_range(2) == 0) begin
          // built from chosen roots, so real roots dominate
          a  = ($signed($urandom_range(15)) - 8) <<< $urandom_range(16, 10);
          if (a == 0) a = 32'sh10000;
          r1 = $signed($urandom_range(255)) - 128;
          r2 = $urandom_range(3) == 0 ? r1 : $signed($urandom_range(255)) - 128;
          send_coefs(a, -(a * (r1 + r2)), a * r1 * r2);
        end else begin
          send_coefs(rand_coef(), rand_coef(), rand_coef());
        end
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 100) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: quadratic_root_solver_core.f
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver_core.sv
dv/quadratic_root_solver_checker.sv
dv/tb_quadratic_root_solver_core.sv
